/* src/uer_pkg.sv */
package uer_pkg;

    localparam int unsigned TRIG_W   = 8;
    localparam int unsigned WIDTH_W  = 16;
    localparam int unsigned PERIOD_W = 18;

    localparam logic [TRIG_W-1:0]   TRIGGER_TICKS_RST = 8'd20;
    localparam logic [WIDTH_W-1:0]  MAX_WIDTH_RST     = 16'd11600;
    localparam logic [PERIOD_W-1:0] PERIOD_TICKS_RST  = 18'd200000;
    localparam logic [WIDTH_W-1:0]  OUT_OF_RANGE      = 16'hFFFF;

    typedef enum logic [1:0] {
        PH_TRIG = 2'd0,
        PH_RISE = 2'd1,
        PH_FALL = 2'd2,
        PH_IDLE = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        REG_TRIGGER_TICKS = 2'd0,
        REG_MAX_WIDTH     = 2'd1,
        REG_PERIOD_TICKS  = 2'd2,
        REG_UNUSED        = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [TRIG_W-1:0]   trigger_ticks;
        logic [WIDTH_W-1:0]  max_width;
        logic [PERIOD_W-1:0] period_ticks;
    } cfg_t;

    typedef struct packed {
        logic               trigger_out;
        logic               width_valid;
        logic [WIDTH_W-1:0] echo_width;
        logic [1:0]         phase;
    } result_t;

endpackage

/* src/uer_cfg.sv */
module uer_cfg
    import uer_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                wr_en,
    input  logic [1:0]          wr_index,
    input  logic [PERIOD_W-1:0] wr_data,
    output cfg_t                cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (reg_idx_t'(wr_index))
                REG_TRIGGER_TICKS: cfg_next.trigger_ticks = wr_data[TRIG_W-1:0];
                REG_MAX_WIDTH:     cfg_next.max_width     = wr_data[WIDTH_W-1:0];
                REG_PERIOD_TICKS:  cfg_next.period_ticks  = wr_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.trigger_ticks <= TRIGGER_TICKS_RST;
            cfg_reg.max_width     <= MAX_WIDTH_RST;
            cfg_reg.period_ticks  <= PERIOD_TICKS_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* src/uer_core.sv */
module uer_core
    import uer_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    tick,
    input  logic    echo_level,
    input  cfg_t    cfg,
    output result_t result
);

    phase_t              phase_reg,     phase_next;
    logic [TRIG_W-1:0]   trig_count_reg, trig_count_next;
    logic [WIDTH_W-1:0]  timer_reg,     timer_next;
    logic [WIDTH_W-1:0]  capture_reg,   capture_next;
    logic [PERIOD_W-1:0] period_reg,    period_next;
    logic                echo_last_reg, echo_last_next;

    logic               rise;
    logic               fall;
    logic [WIDTH_W-1:0] diff;
    logic [PERIOD_W:0]  period_inc;

    assign rise       = echo_level & ~echo_last_reg;
    assign fall       = ~echo_level & echo_last_reg;
    assign diff       = timer_reg - capture_reg;
    assign period_inc = {1'b0, period_reg} + {{PERIOD_W{1'b0}}, 1'b1};

    always_comb begin
        phase_next      = phase_reg;
        trig_count_next = trig_count_reg;
        capture_next    = capture_reg;
        period_next     = period_reg;
        result          = '0;
        result.trigger_out = (phase_reg == PH_TRIG);
        result.phase       = phase_reg;

        unique case (phase_reg)
            PH_TRIG: begin
                trig_count_next = trig_count_reg + 1'b1;
                // wrap to zero acts as reaching the count; zero length behaves as one
                if (trig_count_next == '0 || trig_count_next >= cfg.trigger_ticks) begin
                    phase_next = PH_RISE;
                end
            end
            PH_RISE: begin
                if (rise) begin
                    capture_next = timer_reg;
                    phase_next   = PH_FALL;
                end
            end
            PH_FALL: begin
                if (fall) begin
                    result.width_valid = 1'b1;
                    result.echo_width  = (diff > cfg.max_width) ? OUT_OF_RANGE : diff;
                    phase_next         = PH_IDLE;
                end
            end
            default: begin
            end
        endcase

        // periodic restart wins over whatever phase is active
        if (period_inc >= {1'b0, cfg.period_ticks}) begin
            period_next     = '0;
            phase_next      = PH_TRIG;
            trig_count_next = '0;
        end else begin
            period_next = period_inc[PERIOD_W-1:0];
        end
    end

    assign timer_next     = timer_reg + 1'b1;
    assign echo_last_next = echo_level;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_TRIG;
            trig_count_reg <= '0;
            timer_reg      <= '0;
            capture_reg    <= '0;
            period_reg     <= '0;
            echo_last_reg  <= 1'b0;
        end else if (tick) begin
            phase_reg      <= phase_next;
            trig_count_reg <= trig_count_next;
            timer_reg      <= timer_next;
            capture_reg    <= capture_next;
            period_reg     <= period_next;
            echo_last_reg  <= echo_last_next;
        end
    end

endmodule

/* src/uer_skid.sv */
module uer_skid
    import uer_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  result_t in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t main_data_reg,  main_data_next;
    result_t skid_data_reg,  skid_data_next;
    logic    in_fire;

    assign in_ready = ~skid_valid_reg;
    assign in_fire  = in_valid & in_ready;

    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_data_next  = main_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg) begin
            if (out_ready) begin
                main_data_next  = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end else if (in_fire) begin
            if (!main_valid_reg || out_ready) begin
                main_data_next  = in_data;
                main_valid_next = 1'b1;
            end else begin
                skid_data_next  = in_data;
                skid_valid_next = 1'b1;
            end
        end else if (out_ready) begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

endmodule

/* src/ultrasonic_echo_ranger.sv */
// Output: each result is registered in the output stage before it appears on the m_ side.
// Throughput: one sample per clock while s_tready is high; the tick state is registered and a
// two-entry output stage keeps s_tready high while one result waits downstream.
// Reset: synchronous, aresetn low clears phase, counters, timer and output stage and
// returns the registers to trigger_ticks 20, max_width 11600, period_ticks 200000.
module ultrasonic_echo_ranger
    import uer_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    // sample stream, one transaction per timer tick
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // [0] echo_level, [7:1] zero
    // result stream, one transaction per sample
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [23:0]         m_tdata,   // [0] trigger_out, [16:1] echo_width,
                                           // [18:17] phase, [23:19] zero
    output logic                m_tuser,   // [0] width_valid
    // register writes
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [PERIOD_W-1:0] cfg_data
);

    cfg_t    cfg;
    result_t result;
    result_t out_data;
    logic    s_fire;

    // registers are always writable; the user must write them only while the block is idle (not enforced)
    assign cfg_ready = 1'b1;

    uer_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // each accepted sample advances the measurement state by one tick
    assign s_fire = s_tvalid & s_tready;

    uer_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .tick       (s_fire),
        .echo_level (s_tdata[0]),
        .cfg        (cfg),
        .result     (result)
    );

    // output register plus skid entry decouples m_tready from s_tready
    uer_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    assign m_tdata = {5'b0, out_data.phase, out_data.echo_width, out_data.trigger_out};
    assign m_tuser = out_data.width_valid;

    // trigger is driven exactly in the trigger phase
    a_trig_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[0] == (m_tdata[18:17] == PH_TRIG)))
        else $error("trigger_out disagrees with phase");

    // a width is only reported while waiting for the fall
    a_valid_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[18:17] == PH_FALL))
        else $error("width reported outside wait-fall phase");

    // no width value without a completed measurement
    a_width_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata[16:1] == '0))
        else $error("nonzero width without width_valid");

    // input is refused only while a result is held back by the sink
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && $past(m_tvalid) && !$past(m_tready)))
        else $error("input stalled without downstream backpressure");

endmodule
